// ----- design/aecc_pkg.sv -----
package aecc_pkg;

   // ring geometry: the depth is a power of two set by the address width
   localparam int RING_AW    = 16;
   localparam int RING_DEPTH = 1 << RING_AW;

   localparam int SAMPLE_W = 20;
   localparam int GAIN_W   = 16;
   localparam int CRUSH_W  = 5;
   localparam int PCM_W    = 16;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 16;

   // Q3.16 x Q2.14 product and the widened sums around it
   localparam int PROD_W = SAMPLE_W + GAIN_W;
   localparam int TERM_W = 22;
   localparam int SUM_W  = 23;

   // output scaling: v * 98301 / 655360
   localparam int SCALE_W = 18;
   localparam logic signed [SCALE_W-1:0] SCALE_MUL = 18'sd98301;
   localparam int NUM_W = SUM_W + SCALE_W;
   localparam logic signed [NUM_W-1:0] CLIP_HI = 41'sd21474181120;
   localparam logic signed [NUM_W-1:0] CLIP_LO = -41'sd21474836480;

   // divide by 10 after the shift by 16: floor(x * 419431 / 2^22), exact for x < 699050
   localparam int QX_W   = 19;
   localparam int QX_LSB = 16;
   localparam logic [QX_W-1:0] RECIP_10 = 19'd419431;
   localparam int RECIP_SH = 22;
   localparam int QP_W   = 2 * QX_W;

   typedef enum logic [CSR_IW-1:0] {
      CSR_DELAY_LENGTH  = 2'd0,
      CSR_FEEDBACK_GAIN = 2'd1,
      CSR_WET_MIX       = 2'd2,
      CSR_CRUSH_BITS    = 2'd3
   } csr_index_type;

endpackage

// ----- design/aecc_ram.sv -----
module aecc_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/audio_echo_crush_clip_chain.sv -----
// Feedback echo, bitcrusher and int16 clipper.
// Request channel: req_valid / req_stall carry one Q3.16 dry sample; a request is
// taken at an edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall carry one 16-bit PCM sample per request.
// Config channel: csr_valid / csr_ready with csr_index and csr_data; write only
// while no request is in flight.
// Timing: one request at a time through a six-step sequencer (ring read, gain
// products, ring write and crush, scale multiply, clip, divide). The response
// register loads at the edge that returns the sequencer to idle, and only then
// is a new request taken.
// A held response does not block the next request; only the final step waits for
// the output register to free up when rsp_stall is high.
// Reset: synchronous. Registers return to their defaults (crush depth 16), the
// write pointer goes to zero, and the ring reads as zero: a fill mark tracks which
// entries were written since reset, so no clearing pass is needed.
module audio_echo_crush_clip_chain (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [aecc_pkg::SAMPLE_W-1:0]  req_dry_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [aecc_pkg::PCM_W-1:0]     rsp_pcm_sample,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [aecc_pkg::CSR_IW-1:0]           csr_index,
   input  logic [aecc_pkg::CSR_DW-1:0]           csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_SUM, S_SCALE, S_DIV, S_OUT
   } state_type;

   state_type state_ff;

   logic [aecc_pkg::CSR_DW-1:0]         delay_ff;
   logic signed [aecc_pkg::GAIN_W-1:0]  feedback_ff;
   logic signed [aecc_pkg::GAIN_W-1:0]  mix_ff;
   logic [aecc_pkg::CRUSH_W-1:0]        crush_ff;

   logic [aecc_pkg::RING_AW-1:0]        wp_ff;
   logic                                wrapped_ff;

   logic signed [aecc_pkg::SAMPLE_W-1:0] dry_ff;
   logic                                 echo_en_ff;
   logic                                 rd_valid_ff;
   logic signed [aecc_pkg::PROD_W-1:0]   prod_fb_ff;
   logic signed [aecc_pkg::PROD_W-1:0]   prod_mix_ff;
   logic signed [aecc_pkg::SUM_W-1:0]    v_ff;
   logic signed [aecc_pkg::NUM_W-1:0]    num_ff;
   logic                                 sat_hi_ff;
   logic                                 sat_lo_ff;
   logic                                 neg_ff;
   logic [aecc_pkg::QX_W-1:0]            qx_ff;
   logic                                 rsp_valid_ff;
   logic signed [aecc_pkg::PCM_W-1:0]    rsp_pcm_ff;

   logic                                 accept;
   logic [aecc_pkg::RING_AW-1:0]         back;
   logic [aecc_pkg::RING_AW-1:0]         rd_addr;
   logic                                 rd_valid_in;
   logic [aecc_pkg::SAMPLE_W-1:0]        ring_rdata;
   logic signed [aecc_pkg::SAMPLE_W-1:0] echo;
   logic signed [aecc_pkg::SUM_W-1:0]    fb_sum;
   logic signed [aecc_pkg::SAMPLE_W-1:0] ring_wdata_in;
   logic                                 ring_we;
   logic signed [aecc_pkg::SUM_W-1:0]    mix_sum;
   logic                                 crush_on;
   logic [aecc_pkg::CRUSH_W-1:0]         crush_sh;
   logic [aecc_pkg::SUM_W-1:0]           crush_mag;
   logic [aecc_pkg::SUM_W-1:0]           crush_half;
   logic [aecc_pkg::SUM_W-1:0]           crush_mask;
   logic [aecc_pkg::SUM_W-1:0]           crush_rnd;
   logic signed [aecc_pkg::SUM_W-1:0]    v_in;
   logic [aecc_pkg::NUM_W-1:0]           num_mag;
   logic [aecc_pkg::QP_W-1:0]            q_prod;
   logic [aecc_pkg::PCM_W-1:0]           q_mag;
   logic signed [aecc_pkg::PCM_W-1:0]    rsp_pcm_in;
   logic                                 out_load;

   // round-half-up Q2.14 gain product back to Q3.16
   function automatic logic signed [aecc_pkg::TERM_W-1:0] gain_round(
      input logic signed [aecc_pkg::PROD_W-1:0] p
   );
      logic signed [aecc_pkg::PROD_W:0] s;
      s = (aecc_pkg::PROD_W+1)'(p) + (aecc_pkg::PROD_W+1)'(signed'(15'sd8192));
      return aecc_pkg::TERM_W'(s >>> 14);
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign csr_ready = !reset;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // look-back distance is the delay modulo the ring depth
   assign back    = aecc_pkg::RING_AW'(delay_ff);
   assign rd_addr = wp_ff - back;
   // entries at or past the write pointer stay unwritten until the first wrap
   assign rd_valid_in = wrapped_ff || (rd_addr < wp_ff);

   aecc_ram #(
      .WIDTH(aecc_pkg::SAMPLE_W),
      .DEPTH(aecc_pkg::RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ring_we),
      .wr_addr(wp_ff),
      .wr_data(ring_wdata_in),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(ring_rdata)
   );

   assign echo = (echo_en_ff && rd_valid_ff) ? signed'(ring_rdata) : '0;

   always_comb begin
      fb_sum = aecc_pkg::SUM_W'(dry_ff) + aecc_pkg::SUM_W'(gain_round(prod_fb_ff));
      priority if (fb_sum > aecc_pkg::SUM_W'(signed'(20'sd524287))) begin
         ring_wdata_in = 20'sd524287;
      end else if (fb_sum < aecc_pkg::SUM_W'(signed'(-20'sd524288))) begin
         ring_wdata_in = -20'sd524288;
      end else begin
         ring_wdata_in = aecc_pkg::SAMPLE_W'(fb_sum);
      end
   end

   assign ring_we = (state_ff == S_SUM) && echo_en_ff;

   // crusher: round magnitude to a multiple of 2^(17-bits), halves away from zero
   always_comb begin
      mix_sum    = aecc_pkg::SUM_W'(dry_ff) + aecc_pkg::SUM_W'(gain_round(prod_mix_ff));
      crush_on   = (crush_ff >= 5'd1) && (crush_ff <= 5'd15);
      crush_sh   = 5'd17 - crush_ff;
      crush_mag  = mix_sum[aecc_pkg::SUM_W-1] ? unsigned'(-mix_sum) : unsigned'(mix_sum);
      crush_half = aecc_pkg::SUM_W'(1) << (crush_sh - 5'd1);
      crush_mask = ~((aecc_pkg::SUM_W'(1) << crush_sh) - aecc_pkg::SUM_W'(1));
      crush_rnd  = (crush_mag + crush_half) & crush_mask;
      if (!crush_on) begin
         v_in = mix_sum;
      end else if (mix_sum[aecc_pkg::SUM_W-1]) begin
         v_in = -signed'(crush_rnd);
      end else begin
         v_in = signed'(crush_rnd);
      end
   end

   always_comb begin
      num_mag    = num_ff[aecc_pkg::NUM_W-1] ? unsigned'(-num_ff) : unsigned'(num_ff);
      q_prod     = aecc_pkg::QP_W'(qx_ff) * aecc_pkg::QP_W'(aecc_pkg::RECIP_10);
      q_mag      = q_prod[aecc_pkg::RECIP_SH +: aecc_pkg::PCM_W];
      priority if (sat_hi_ff) begin
         rsp_pcm_in = 16'sd32767;
      end else if (sat_lo_ff) begin
         rsp_pcm_in = -16'sd32768;
      end else if (neg_ff) begin
         rsp_pcm_in = -signed'(q_mag);
      end else begin
         rsp_pcm_in = signed'(q_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         delay_ff     <= '0;
         feedback_ff  <= '0;
         mix_ff       <= '0;
         crush_ff     <= 5'd16;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (aecc_pkg::csr_index_type'(csr_index))
               aecc_pkg::CSR_DELAY_LENGTH:  delay_ff    <= csr_data;
               aecc_pkg::CSR_FEEDBACK_GAIN: feedback_ff <= signed'(csr_data);
               aecc_pkg::CSR_WET_MIX:       mix_ff      <= signed'(csr_data);
               aecc_pkg::CSR_CRUSH_BITS:    crush_ff    <= csr_data[aecc_pkg::CRUSH_W-1:0];
               default: ;
            endcase
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_pcm_ff   <= rsp_pcm_in;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  dry_ff      <= req_dry_sample;
                  echo_en_ff  <= (delay_ff != '0);
                  rd_valid_ff <= rd_valid_in;
                  state_ff    <= S_READ;
               end
            end
            S_READ: begin
               prod_fb_ff  <= echo * feedback_ff;
               prod_mix_ff <= echo * mix_ff;
               state_ff    <= S_SUM;
            end
            S_SUM: begin
               if (echo_en_ff) begin
                  wp_ff <= wp_ff + 1'b1;
                  if (wp_ff == '1) begin
                     wrapped_ff <= 1'b1;
                  end
               end
               v_ff     <= v_in;
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               num_ff   <= aecc_pkg::NUM_W'(v_ff) * aecc_pkg::NUM_W'(aecc_pkg::SCALE_MUL);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               sat_hi_ff <= num_ff > aecc_pkg::CLIP_HI;
               sat_lo_ff <= num_ff < aecc_pkg::CLIP_LO;
               neg_ff    <= num_ff[aecc_pkg::NUM_W-1];
               qx_ff     <= num_mag[aecc_pkg::QX_LSB +: aecc_pkg::QX_W];
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_sample = rsp_pcm_ff;

endmodule

// ----- sim/audio_echo_crush_clip_chain_test.sv -----
module audio_echo_crush_clip_chain_test;
   import aecc_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 20;
   localparam longint PCM_DEN    = 655360;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_W-1:0]    req_dry_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [PCM_W-1:0]       rsp_pcm_sample;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IW-1:0]             csr_index = CSR_DELAY_LENGTH;
   logic [CSR_DW-1:0]             csr_data = '0;

   // model of the echo chain
   logic signed [SAMPLE_W-1:0]    echo_model [RING_DEPTH];
   logic [RING_AW-1:0]            wptr_model;
   logic [CSR_DW-1:0]             delay_model;
   logic signed [GAIN_W-1:0]      feedback_model;
   logic signed [GAIN_W-1:0]      mix_model;
   logic [CRUSH_W-1:0]            crush_model;

   logic signed [PCM_W-1:0]       pcm_expected [$];
   int samples_sent   = 0;
   int pcm_checked    = 0;
   int mismatches     = 0;
   int reg_writes     = 0;
   int settings_used  = 0;
   int send_gap_pct   = 0;
   int recv_gap_pct   = 0;
   int hold_trigger   = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int stall_watch    = 0;

   audio_echo_crush_clip_chain dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_dry_sample (req_dry_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pcm_sample (rsp_pcm_sample),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #6 clock = ~clock;

   // Q3.16 x Q2.14 back to Q3.16, round half up
   function automatic longint apply_gain(input longint sample, input longint gain);
      longint prod;
      prod = sample * gain + 8192;
      return prod >>> 14;
   endfunction

   function automatic logic signed [PCM_W-1:0] predict_pcm(
      input logic signed [SAMPLE_W-1:0] dry);
      longint echo;
      longint fed;
      longint v;
      longint mag;
      longint step;
      longint num;
      longint res;
      logic [RING_AW-1:0] rd;
      int bits;
      echo = 0;
      if (delay_model != 0) begin
         rd = wptr_model - delay_model[RING_AW-1:0];
         echo = echo_model[rd];
         fed = dry + apply_gain(echo, feedback_model);
         if (fed > 524287) fed = 524287;
         else if (fed < -524288) fed = -524288;
         echo_model[wptr_model] = fed[SAMPLE_W-1:0];
         wptr_model = wptr_model + 1'b1;
      end
      v = dry + apply_gain(echo, mix_model);
      bits = crush_model;
      if (bits >= 1 && bits <= 15) begin
         step = longint'(1) << (17 - bits);
         mag = (v < 0) ? -v : v;
         mag = ((mag + step / 2) / step) * step;
         v = (v < 0) ? -mag : mag;
      end
      num = v * 98301;
      if (num > 32767 * PCM_DEN) res = 32767;
      else if (num < -32768 * PCM_DEN) res = -32768;
      else res = num / PCM_DEN;
      return res[PCM_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // response checker
   always @(posedge clock) begin : check_pcm
      logic signed [PCM_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pcm_expected.size() == 0) begin
            report_mismatch($sformatf("pcm sample %0d with no request pending",
                                      rsp_pcm_sample));
         end else begin
            want = pcm_expected.pop_front();
            if (rsp_pcm_sample !== want)
               report_mismatch($sformatf("pcm_sample got %0d want %0d",
                                         rsp_pcm_sample, want));
            pcm_checked++;
         end
      end
   end

   // output side: random stalls plus an occasional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         stall_watch <= 0;
      end else if (stall_watch >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", stall_watch);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_watch <= stall_watch + 1;
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] dry);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dry_sample <= dry;
      do @(posedge clock); while (!(req_valid && !req_stall));
      pcm_expected.push_back(predict_pcm(dry));
      samples_sent++;
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pcm_expected.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DELAY_LENGTH:  delay_model = data;
         CSR_FEEDBACK_GAIN: feedback_model = signed'(data);
         CSR_WET_MIX:       mix_model = signed'(data);
         CSR_CRUSH_BITS:    crush_model = data[CRUSH_W-1:0];
      endcase
      reg_writes++;
   endtask

   task automatic program_chain(input logic [CSR_DW-1:0] dly, input logic [CSR_DW-1:0] fbk,
                                input logic [CSR_DW-1:0] mix, input logic [CSR_DW-1:0] crush);
      release_req();
      wait_drained();
      csr_write(CSR_DELAY_LENGTH, dly);
      csr_write(CSR_FEEDBACK_GAIN, fbk);
      csr_write(CSR_WET_MIX, mix);
      csr_write(CSR_CRUSH_BITS, crush);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_dry();
      int unsigned r;
      r = $urandom_range(19);
      if (r < 12)
         return SAMPLE_W'($urandom);
      else if (r < 17)
         return SAMPLE_W'(int'($urandom_range(32767)) - 16384);
      else if (r == 17)
         return $urandom_range(1) ? 20'sd524287 : -20'sd524288;
      else if (r == 18)
         return SAMPLE_W'(int'($urandom_range(8)) - 4);
      else
         return SAMPLE_W'(int'($urandom_range(2047)) - 1024
                          + ($urandom_range(1) ? 523263 : -523264));
   endfunction

   function automatic logic [CSR_DW-1:0] pick_delay();
      case ($urandom_range(9))
         0:          return 16'd0;
         1:          return 16'd1;
         2, 3, 4, 5: return CSR_DW'($urandom_range(2, 40));
         6, 7:       return CSR_DW'($urandom_range(41, 400));
         8:          return CSR_DW'($urandom_range(401, 65535));
         default:    return 16'd65535;
      endcase
   endfunction

   function automatic logic [CSR_DW-1:0] pick_gain();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2, 3, 4: return CSR_DW'($urandom);
         default: return CSR_DW'(int'($urandom_range(32767)) - 16384);
      endcase
   endfunction

   // one case puts junk in the upper data bits above the 5-bit crush field
   function automatic logic [CSR_DW-1:0] pick_crush();
      case ($urandom_range(7))
         0, 1, 2, 3: return CSR_DW'($urandom_range(16));
         4, 5:       return CSR_DW'($urandom_range(17, 31));
         6:          return {11'($urandom), 5'($urandom_range(1, 15))};
         default:    return 16'd16;
      endcase
   endfunction

   // reset defaults: no echo, crush off
   task automatic test_passthrough_extremes();
      send_sample(20'sd524287);
      send_sample(-20'sd524288);
      send_sample(20'sd0);
      send_sample(-20'sd1);
      send_sample(20'sd1);
   endtask

   // ties at the coarsest and finest crush depths, then depth zero
   task automatic test_crush_depths();
      program_chain(16'd0, 16'd0, 16'd0, 16'd1);
      send_sample(20'sd32768);
      send_sample(-20'sd32768);
      program_chain(16'd0, 16'd0, 16'd0, 16'd15);
      send_sample(20'sd2);
      send_sample(-20'sd2);
      program_chain(16'd0, 16'd0, 16'd0, 16'd0);
      send_sample(20'sd3);
   endtask

   // read-before-write on back-to-back samples, feedback saturating the ring
   task automatic test_unit_delay_feedback();
      program_chain(16'd1, 16'h7fff, 16'h8000, 16'd16);
      send_sample(20'sd524287);
      send_sample(20'sd524287);
      send_sample(-20'sd524288);
      send_sample(20'sd100000);
   endtask

   task automatic test_negative_feedback();
      program_chain(16'd2, 16'h8000, 16'h7fff, 16'd8);
      send_sample(20'sd524287);
      send_sample(-20'sd524288);
      send_sample(20'sd12345);
      send_sample(20'sd0);
      send_sample(-20'sd7);
   endtask

   task automatic test_full_delay();
      program_chain(16'd65535, 16'd16384, 16'd16384, 16'd16);
      send_sample(20'sd262144);
      send_sample(-20'sd1);
      send_sample(20'sd524287);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int segments, input int per_segment);
      send_gap_pct = send_pct;
      recv_gap_pct <= recv_pct;
      repeat (segments) begin
         program_chain(pick_delay(), pick_gain(), pick_gain(), pick_crush());
         repeat (per_segment) send_sample(pick_dry());
      end
   endtask

   // output held long enough that the block backs up onto the request side
   task automatic test_output_hold();
      send_gap_pct = 0;
      recv_gap_pct <= 0;
      program_chain(16'd5, 16'd12000, 16'hd000, 16'd12);
      hold_trigger <= hold_trigger + 1;
      repeat (30) send_sample(pick_dry());
   endtask

   task automatic test_sender_drain();
      repeat (20) send_sample(pick_dry());
      release_req();
      wait_drained();
      repeat (20) send_sample(pick_dry());
   endtask

   initial begin
      for (int i = 0; i < RING_DEPTH; i++) echo_model[i] = '0;
      wptr_model = '0;
      delay_model = '0;
      feedback_model = '0;
      mix_model = '0;
      crush_model = 5'd16;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_passthrough_extremes();
      test_crush_depths();
      test_unit_delay_feedback();
      test_negative_feedback();
      test_full_delay();
      test_random_traffic(8, 47, 4, 75);
      test_random_traffic(47, 8, 4, 75);
      test_output_hold();
      test_sender_drain();
      test_random_traffic(0, 0, 4, 65);

      release_req();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pcm_expected.size() != 0)
         report_mismatch($sformatf("%0d pcm samples never arrived", pcm_expected.size()));

      $display("run: %0d dry samples, %0d pcm samples checked, %0d register writes, %0d settings",
               samples_sent, pcm_checked, reg_writes, settings_used);
      $display("run: delays 0/1/max, gain extremes, crush depths 0..31, output hold, drain pause");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
